// ----- hw/rtl/dual_hash_node_sync_checker_assert.svh -----
// Assertion helpers used by the top-level RTL file.
// Each macro expects clk and rst_n in scope.
`ifndef DUAL_HASH_NODE_SYNC_CHECKER_ASSERT_SVH
`define DUAL_HASH_NODE_SYNC_CHECKER_ASSERT_SVH

// Same-cycle implication
`define DHNSC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dhnsc assertion failed");

// Next-cycle implication
`define DHNSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dhnsc assertion failed");

`endif

// ----- hw/rtl/dhnsc_pkg.sv -----
package dhnsc_pkg;

  localparam int HASH_W = 64;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 6;

  // Maximum number of nodes held in the table
  localparam logic [CNT_W-1:0] NODE_LIMIT = 6'd32;

  // Seeds of the two running hashes
  localparam logic [HASH_W-1:0] SEED_A = 64'd5381;
  localparam logic [HASH_W-1:0] SEED_B = 64'h0000_0000_9e37_79b9;

  // Closing transaction handed from the hash stage to the tally stage
  typedef struct packed {
    logic              clear;
    logic [HASH_W-1:0] hash_a;
    logic [HASH_W-1:0] hash_b;
  } close_t;

endpackage

// ----- hw/rtl/dhnsc_hash.sv -----
module dhnsc_hash (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic                           in_has_byte,
  input  logic [dhnsc_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                           in_last,
  output logic                           cls_valid,
  input  logic                           cls_ready,
  output dhnsc_pkg::close_t              cls
);

  // Input register
  logic                          s1_v_r;
  logic                          s1_kind_r;
  logic                          s1_has_r;
  logic [dhnsc_pkg::BYTE_W-1:0]  s1_byte_r;
  logic                          s1_last_r;

  // Running hashes
  logic [dhnsc_pkg::HASH_W-1:0]  run_a_r, run_a_nxt;
  logic [dhnsc_pkg::HASH_W-1:0]  run_b_r, run_b_nxt;
  logic [dhnsc_pkg::HASH_W-1:0]  fold_a, fold_b, byte_ext;

  // Close register
  logic                          cls_v_r;
  dhnsc_pkg::close_t             cls_r;

  logic s1_needs_slot;
  logic slot_free;
  logic s1_go;

  // Only closing and clear items occupy the close register
  assign s1_needs_slot = s1_kind_r | s1_last_r;
  assign slot_free     = !cls_v_r || cls_ready;
  assign s1_go         = s1_v_r && (!s1_needs_slot || slot_free);
  assign in_ready      = !s1_v_r || s1_go;

  // Fold the held byte into both hashes
  always_comb begin
    byte_ext = {{(dhnsc_pkg::HASH_W-dhnsc_pkg::BYTE_W){1'b0}}, s1_byte_r};
    if (s1_has_r) begin
      fold_a = (run_a_r << 5) + run_a_r + byte_ext;
      fold_b = run_b_r ^ ((run_b_r << 6) + (run_b_r >> 2) + byte_ext);
    end else begin
      fold_a = run_a_r;
      fold_b = run_b_r;
    end
  end

  // Next running hash: back to the seeds on clear or node close
  always_comb begin
    run_a_nxt = run_a_r;
    run_b_nxt = run_b_r;
    if (s1_go) begin
      if (s1_kind_r || s1_last_r) begin
        run_a_nxt = dhnsc_pkg::SEED_A;
        run_b_nxt = dhnsc_pkg::SEED_B;
      end else begin
        run_a_nxt = fold_a;
        run_b_nxt = fold_b;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      cls_v_r <= 1'b0;
      run_a_r <= dhnsc_pkg::SEED_A;
      run_b_r <= dhnsc_pkg::SEED_B;
    end else begin
      run_a_r <= run_a_nxt;
      run_b_r <= run_b_nxt;
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (s1_go && s1_needs_slot) begin
        cls_v_r <= 1'b1;
      end else if (cls_ready) begin
        cls_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= in_kind;
      s1_has_r  <= in_has_byte;
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last;
    end
    if (s1_go && s1_needs_slot) begin
      cls_r.clear  <= s1_kind_r;
      cls_r.hash_a <= fold_a;
      cls_r.hash_b <= fold_b;
    end
  end

  assign cls_valid = cls_v_r;
  assign cls       = cls_r;

endmodule

// ----- hw/rtl/dual_hash_node_sync_checker.sv -----
// dual_hash_node_sync_checker
//
// Input channel (in_valid/in_ready): one transaction per byte of a node's
// weight data. in_kind = 1 clears all nodes and the master pair. in_last = 1
// closes the current node; with in_has_byte = 0 it closes without adding a byte.
// Output channel (out_valid/out_ready): one result per closing transaction
// with the accept/reject status, node, synced and mismatched counts, the
// all-match flag and the four hash words (rejected nodes report zeros).
// Path: a closing transaction passes the input register, the close register
// and the output register before it shows on out_valid.
// Throughput: one transaction per cycle while in_ready is high; each byte costs
// one add chain per hash in the input stage, and the master compare plus counts
// sit in the output stage.
// Reset (rst_n low, synchronous): pipeline empties, hashes return to their
// seeds, counts and master pair clear.
// When the receiver stalls, the result holds in the output register; one more
// closing transaction waits in the close register and a second one in the
// input register, byte transactions before it still flow; then in_ready drops.
`include "dual_hash_node_sync_checker_assert.svh"

module dual_hash_node_sync_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic                          in_has_byte,
  input  logic [dhnsc_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [dhnsc_pkg::CNT_W-1:0]   out_node_count,
  output logic [dhnsc_pkg::CNT_W-1:0]   out_synced_count,
  output logic [dhnsc_pkg::CNT_W-1:0]   out_mismatched_count,
  output logic                          out_all_match,
  output logic [dhnsc_pkg::HASH_W-1:0]  out_hash_word_a,
  output logic [dhnsc_pkg::HASH_W-1:0]  out_hash_word_b,
  output logic [dhnsc_pkg::HASH_W-1:0]  out_hash_word_c,
  output logic [dhnsc_pkg::HASH_W-1:0]  out_hash_word_d
);

  logic              cls_valid;
  logic              cls_ready;
  dhnsc_pkg::close_t cls;
  logic              cls_go;

  // Hash stage
  dhnsc_hash u_hash (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_has_byte  (in_has_byte),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .cls_valid    (cls_valid),
    .cls_ready    (cls_ready),
    .cls          (cls)
  );

  // Tally state
  logic [dhnsc_pkg::CNT_W-1:0]  held_r, held_nxt;
  logic [dhnsc_pkg::CNT_W-1:0]  synced_r, synced_nxt;
  logic [dhnsc_pkg::HASH_W-1:0] master_a_r, master_a_nxt;
  logic [dhnsc_pkg::HASH_W-1:0] master_b_r, master_b_nxt;

  // Output register
  logic                         out_v_r;
  logic                         status_r;
  logic [dhnsc_pkg::CNT_W-1:0]  node_cnt_r, sync_cnt_r, mism_cnt_r;
  logic                         all_match_r;
  logic [dhnsc_pkg::HASH_W-1:0] word_a_r, word_b_r, word_c_r, word_d_r;

  logic                         full;
  logic                         first;
  logic                         match;
  logic [dhnsc_pkg::CNT_W-1:0]  mism;
  logic [dhnsc_pkg::HASH_W-1:0] ha, hb;

  // Clears never need the output register
  assign cls_ready = cls.clear || !out_v_r || out_ready;
  assign cls_go    = cls_valid && cls_ready;

  // Master compare and count update
  always_comb begin
    full  = (held_r >= dhnsc_pkg::NODE_LIMIT);
    first = (held_r == '0);
    match = first || ((cls.hash_a == master_a_r) && (cls.hash_b == master_b_r));
    held_nxt     = held_r;
    synced_nxt   = synced_r;
    master_a_nxt = master_a_r;
    master_b_nxt = master_b_r;
    ha = '0;
    hb = '0;
    if (cls_go) begin
      if (cls.clear) begin
        held_nxt     = '0;
        synced_nxt   = '0;
        master_a_nxt = '0;
        master_b_nxt = '0;
      end else if (!full) begin
        ha       = cls.hash_a;
        hb       = cls.hash_b;
        held_nxt = held_r + 1'b1;
        if (first) begin
          master_a_nxt = cls.hash_a;
          master_b_nxt = cls.hash_b;
        end
        if (match) begin
          synced_nxt = synced_r + 1'b1;
        end
      end
    end
    mism = held_nxt - synced_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r    <= 1'b0;
      held_r     <= '0;
      synced_r   <= '0;
      master_a_r <= '0;
      master_b_r <= '0;
    end else begin
      held_r     <= held_nxt;
      synced_r   <= synced_nxt;
      master_a_r <= master_a_nxt;
      master_b_r <= master_b_nxt;
      if (cls_go && !cls.clear) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cls_go && !cls.clear) begin
      status_r    <= full;
      node_cnt_r  <= held_nxt;
      sync_cnt_r  <= synced_nxt;
      mism_cnt_r  <= mism;
      all_match_r <= (held_nxt != '0) && (mism == '0);
      word_a_r    <= ha;
      word_b_r    <= hb;
      word_c_r    <= ha ^ hb;
      word_d_r    <= ha + hb;
    end
  end

  assign out_valid            = out_v_r;
  assign out_status           = status_r;
  assign out_node_count       = node_cnt_r;
  assign out_synced_count     = sync_cnt_r;
  assign out_mismatched_count = mism_cnt_r;
  assign out_all_match        = all_match_r;
  assign out_hash_word_a      = word_a_r;
  assign out_hash_word_b      = word_b_r;
  assign out_hash_word_c      = word_c_r;
  assign out_hash_word_d      = word_d_r;

  // Invariants of the tally
  `DHNSC_ASSERT_IMPL(a_synced_le_held, 1'b1, synced_r <= held_r)
  `DHNSC_ASSERT_IMPL(a_held_in_limit, 1'b1, held_r <= dhnsc_pkg::NODE_LIMIT)
  `DHNSC_ASSERT_IMPL(a_first_is_synced, held_r != '0, synced_r != '0)
  `DHNSC_ASSERT_NEXT(a_clear_empties, cls_go && cls.clear, held_r == '0 && synced_r == '0)
  `DHNSC_ASSERT_IMPL(a_reject_at_limit, out_v_r && status_r,
                     node_cnt_r == dhnsc_pkg::NODE_LIMIT && word_a_r == '0)

endmodule
